FILE: rtl/core/ssmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssmt_pkg
// Shared types, sizes and codes of the signed shape membership test core.
// ----------------------------------------------------------------------------
package ssmt_pkg;

   localparam int COORD_MAX  = 1023;
   localparam int MAX_SHAPES = 16;

   localparam int COORD_W = 10;
   localparam int COUNT_W = $clog2(MAX_SHAPES + 1);
   localparam int IDX_W   = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int HITS_W  = COUNT_W + 1;
   localparam int SQ_W    = 2 * COORD_W;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      FN_RECT  = 2'd0,
      FN_CIRC  = 2'd1,
      FN_QUERY = 2'd2,
      FN_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_AREA = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic               circle;
      logic               minus;
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] d;
   } entry_type;

   function automatic logic out_of_area(input logic [COORD_W-1:0] v);
      return int'(v) > COORD_MAX;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/signed_shape_membership_test_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_shape_membership_test_core
// Table of signed rectangles and circles; point queries sum signed hits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                       | tuser
//  req     | in  | negative, coord_a, coord_b, coord_c,     | func
//          |     | coord_d, zero pad                        |
//  rsp     | out | inside_res, entry_count, zero pad        | status
//
//  Add, clear, rejected query and query of an empty table: the result is
//  valid in the cycle after accept.
//  Query: one memory read a cycle for each of the N stored entries from
//  the single shape memory port, then two compute stages and a final compare.
//  One beat at a time; req_tready drops while a query scans.
//  The result register holds its beat until rsp_tready; reset empties it.
//  Synchronous reset zeroes the entry count; the memory needs no clearing.
// ----------------------------------------------------------------------------
module signed_shape_membership_test_core (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // negative, coord_a, coord_b, coord_c, coord_d, pad
   input  wire [ssmt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func
   input  wire [1:0]                       req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // inside_res, entry_count, pad
   output logic [ssmt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                      rsp_tuser
);
   import ssmt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   entry_type shape_mem [MAX_SHAPES];

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_inside_ff, rsp_inside_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic               issue_ff, issue_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   entry_type          rd_data_ff;
   logic               s1_valid_ff, s1_valid_in, s1_last_ff, s1_last_in;
   logic               s2_valid_ff, s2_last_ff;
   logic [SQ_W-1:0]    dx2_ff, dy2_ff, r2_ff;
   logic               rect_hit_ff, circle_ff, minus_ff;
   logic signed [HITS_W-1:0] hits_ff, hits_in;

   func_type           func;
   logic               neg;
   logic [COORD_W-1:0] ca, cb, cc, cd, dx, dy;
   logic               accept, wr_en, circ_hit, hit;
   entry_type          wr_entry;

   assign func = func_type'(req_tuser);
   assign neg  = req_tdata[0];
   assign ca   = req_tdata[COORD_W:1];
   assign cb   = req_tdata[2*COORD_W:COORD_W+1];
   assign cc   = req_tdata[3*COORD_W:2*COORD_W+1];
   assign cd   = req_tdata[4*COORD_W:3*COORD_W+1];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - COUNT_W - 1){1'b0}}, used_ff, rsp_inside_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign dx = (qx_ff >= rd_data_ff.a) ? qx_ff - rd_data_ff.a : rd_data_ff.a - qx_ff;
   assign dy = (qy_ff >= rd_data_ff.b) ? qy_ff - rd_data_ff.b : rd_data_ff.b - qy_ff;

   assign circ_hit = ({1'b0, dx2_ff} + {1'b0, dy2_ff}) <= {1'b0, r2_ff};
   assign hit      = circle_ff ? circ_hit : rect_hit_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      issue_in      = issue_ff;
      rd_idx_in     = rd_idx_ff;
      s1_valid_in   = 1'b0;
      s1_last_in    = 1'b0;
      hits_in       = hits_ff;
      wr_en         = 1'b0;
      wr_entry      = '{circle: (func == FN_CIRC), minus: neg, a: ca, b: cb, c: cc,
                        d: (func == FN_CIRC) ? '0 : cd};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_inside_in = 1'b0;
               rsp_status_in = ST_OK;
               case (func)
                  FN_RECT, FN_CIRC: begin
                     rsp_valid_in = 1'b1;
                     if (out_of_area(ca) || out_of_area(cb) || out_of_area(cc) ||
                         (func == FN_RECT && out_of_area(cd))) begin
                        rsp_status_in = ST_AREA;
                     end else if (used_ff >= COUNT_W'(MAX_SHAPES)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        used_in = used_ff + 1'b1;
                     end
                  end
                  FN_QUERY: begin
                     if (out_of_area(ca) || out_of_area(cb)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_AREA;
                     end else if (used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        qx_in        = ca;
                        qy_in        = cb;
                        issue_in     = 1'b1;
                        rd_idx_in    = '0;
                        hits_in      = '0;
                        state_in     = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     used_in      = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               s1_valid_in = 1'b1;
               rd_idx_in   = rd_idx_ff + 1'b1;
               if (rd_idx_ff == IDX_W'(used_ff - 1'b1)) begin
                  s1_last_in = 1'b1;
                  issue_in   = 1'b0;
               end
            end
            if (s2_valid_ff) begin
               if (hit) begin
                  hits_in = minus_ff ? hits_ff - 1'b1 : hits_ff + 1'b1;
               end
               if (s2_last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = hits_ff > 0;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // no read can meet a write: the scan only runs with the request side closed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         shape_mem[used_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_data_ff <= shape_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         s2_valid_ff  <= s1_valid_ff;
         s2_last_ff   <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rd_idx_ff     <= rd_idx_in;
      hits_ff       <= hits_in;
      dx2_ff        <= SQ_W'(dx) * SQ_W'(dx);
      dy2_ff        <= SQ_W'(dy) * SQ_W'(dy);
      r2_ff         <= SQ_W'(rd_data_ff.c) * SQ_W'(rd_data_ff.c);
      rect_hit_ff   <= (qx_ff >= rd_data_ff.a) && (qy_ff >= rd_data_ff.b) &&
                       (qx_ff <= rd_data_ff.c) && (qy_ff <= rd_data_ff.d);
      circle_ff     <= rd_data_ff.circle;
      minus_ff      <= rd_data_ff.minus;
   end

endmodule
`default_nettype wire

FILE: rtl/core/ssmt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssmt_checker
// Port-level checks of the signed shape membership test core.
// ----------------------------------------------------------------------------
module ssmt_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire [ssmt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire [1:0]                       req_tuser,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [ssmt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire [1:0]                       rsp_tuser
);
   import ssmt_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[COUNT_W:1]) <= MAX_SHAPES)
      else $error("entry count beyond table size");

   a_fail_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> !rsp_tdata[0])
      else $error("inside flagged on a failed beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_AREA || rsp_tuser == ST_FULL)
      else $error("unknown status code");

   // clear answers in the next cycle with an empty table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FN_CLEAR
      |=> rsp_tvalid && rsp_tdata[COUNT_W:1] == '0 && rsp_tuser == ST_OK)
      else $error("clear beat not answered with empty table");

endmodule

bind signed_shape_membership_test_core ssmt_checker u_ssmt_checker (.*);
`default_nettype wire
